@@ hdl/image_rotate_mirror_address_gen_macros.svh @@
// ----------------------------------------------------------------------------
// image rotate / mirror address generator assertion macros
// shared property forms for the address generator modules
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_MIRROR_ADDRESS_GEN_MACROS_SVH
`define IMAGE_ROTATE_MIRROR_ADDRESS_GEN_MACROS_SVH

// consequent holds in the same cycle
`define IRM_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the next cycle
`define IRM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/irm_pkg.sv @@
// ----------------------------------------------------------------------------
// irm_pkg
// types, constants and the frame geometry function of the address generator
// ----------------------------------------------------------------------------
`default_nettype none

package irm_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int ROW_ALIGN = 16;

    localparam int DIM_W      = 13;
    localparam int CNT_W      = 12;
    localparam int CHAN_W     = 3;
    localparam int MODE_W     = 3;
    localparam int ADDR_W     = 26;
    localparam int STRIDE_W   = 15;
    localparam int PIXEL_W    = 32;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int RAW_W      = DIM_W + 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_MIRROR        = 3'd0,
        MODE_ROT90         = 3'd1,
        MODE_ROT90_MIRROR  = 3'd2,
        MODE_ROT180        = 3'd3,
        MODE_ROT180_MIRROR = 3'd4,
        MODE_ROT270        = 3'd5,
        MODE_ROT270_MIRROR = 3'd6
    } mode_t;

    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [STRIDE_W-1:0] stride;
        logic [ADDR_W-1:0]   pstep;
        logic [ADDR_W-1:0]   rstep;
        logic [ADDR_W-1:0]   start;
    } geom_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    function automatic geom_t derive_geom(
        input logic [MODE_W-1:0] mode,
        input logic [DIM_W-1:0]  src_w,
        input logic [DIM_W-1:0]  src_h,
        input logic [CHAN_W-1:0] chan
    );
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [DIM_W-1:0]    dw;
        logic [DIM_W-1:0]    dh;
        logic [DIM_W-1:0]    dw_m1;
        logic                four;
        logic                swap;
        logic [RAW_W-1:0]    raw;
        logic [RAW_W-1:0]    rounded;
        logic [RAW_W-1:0]    col_raw;
        logic [ADDR_W-1:0]   ch_a;
        logic [ADDR_W-1:0]   stride_a;
        logic [ADDR_W-1:0]   last_col;
        logic [ADDR_W-1:0]   last_row;
        logic [ADDR_W-1:0]   neg_ch;
        logic [ADDR_W-1:0]   neg_stride;
        geom_t               g;
        w    = clamp_dim(src_w);
        h    = clamp_dim(src_h);
        four = (chan != CHAN_W'(3));
        case (mode)
            MODE_ROT90, MODE_ROT90_MIRROR, MODE_ROT270, MODE_ROT270_MIRROR: swap = 1'b1;
            default: swap = 1'b0;
        endcase
        dw    = swap ? h : w;
        dh    = swap ? w : h;
        dw_m1 = dw - DIM_W'(1);
        // times three or four without a multiplier
        raw     = four ? (RAW_W'(dw) << 2) : ((RAW_W'(dw) << 1) + RAW_W'(dw));
        col_raw = four ? (RAW_W'(dw_m1) << 2) : ((RAW_W'(dw_m1) << 1) + RAW_W'(dw_m1));
        rounded = (raw + RAW_W'(ROW_ALIGN - 1)) & ~RAW_W'(ROW_ALIGN - 1);
        ch_a       = four ? ADDR_W'(4) : ADDR_W'(3);
        stride_a   = ADDR_W'(rounded);
        last_col   = ADDR_W'(col_raw);
        last_row   = ADDR_W'((dh - DIM_W'(1)) * rounded);
        neg_ch     = ADDR_W'(0) - ch_a;
        neg_stride = ADDR_W'(0) - stride_a;
        g.width  = w;
        g.height = h;
        g.stride = STRIDE_W'(rounded);
        case (mode)
            MODE_ROT90: begin
                g.pstep = stride_a;   g.rstep = neg_ch;     g.start = last_col;
            end
            MODE_ROT90_MIRROR: begin
                g.pstep = neg_stride; g.rstep = neg_ch;     g.start = last_row + last_col;
            end
            MODE_ROT180: begin
                g.pstep = neg_ch;     g.rstep = neg_stride; g.start = last_row + last_col;
            end
            MODE_ROT180_MIRROR: begin
                g.pstep = ch_a;       g.rstep = neg_stride; g.start = last_row;
            end
            MODE_ROT270: begin
                g.pstep = neg_stride; g.rstep = ch_a;       g.start = last_row;
            end
            MODE_ROT270_MIRROR: begin
                g.pstep = stride_a;   g.rstep = ch_a;       g.start = '0;
            end
            default: begin
                g.pstep = neg_ch;     g.rstep = stride_a;   g.start = last_col;
            end
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

@@ hdl/image_rotate_mirror_address_gen.sv @@
// a transferred pixel is held in the input register, then moves to the result register when it advances
// throughput: one pixel per cycle while the output is not stalled, set by the single address update per pixel
// a stalled output holds its result; the input register still takes one pixel
// reset: registers to mode mirror, 1 x 1 frame, four channels, counters cleared
// ----------------------------------------------------------------------------
// image_rotate_mirror_address_gen
// destination byte offsets for raster pixels under rotate and mirror modes
// ----------------------------------------------------------------------------
`default_nettype none

module image_rotate_mirror_address_gen import irm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PIXEL_W-1:0]    pixel_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [ADDR_W-1:0]          dest_offset,
    output logic [PIXEL_W-1:0]         pixel_out,
    output logic [STRIDE_W-1:0]        dest_row_stride,
    output logic                       frame_last
);

    geom_t geom;

    irm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom      (geom)
    );

    irm_core u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .geom            (geom),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_data      (pixel_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .dest_offset     (dest_offset),
        .pixel_out       (pixel_out),
        .dest_row_stride (dest_row_stride),
        .frame_last      (frame_last)
    );

endmodule

`default_nettype wire

@@ hdl/irm_cfg.sv @@
// ----------------------------------------------------------------------------
// irm_cfg
// configuration registers and registered destination frame geometry
// ----------------------------------------------------------------------------
`default_nettype none

module irm_cfg import irm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output geom_t                      geom
);

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  width_next;
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  height_next;
    logic [CHAN_W-1:0] chan_reg;
    logic [CHAN_W-1:0] chan_next;
    geom_t             geom_reg;
    geom_t             geom_next;

    always_comb
    begin
        mode_next   = mode_reg;
        width_next  = width_reg;
        height_next = height_reg;
        chan_next   = chan_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:     mode_next   = cfg_wdata[MODE_W-1:0];
                REG_WIDTH:    width_next  = cfg_wdata[DIM_W-1:0];
                REG_HEIGHT:   height_next = cfg_wdata[DIM_W-1:0];
                REG_CHANNELS: chan_next   = cfg_wdata[CHAN_W-1:0];
                default: ;
            endcase
        end
        // geometry follows the new values at the write edge
        geom_next = derive_geom(mode_next, width_next, height_next, chan_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MIRROR;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            chan_reg   <= CHAN_W'(4);
            geom_reg   <= derive_geom(MODE_MIRROR, DIM_W'(1), DIM_W'(1), CHAN_W'(4));
        end
        else
        begin
            mode_reg   <= mode_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            chan_reg   <= chan_next;
            geom_reg   <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

`default_nettype wire

@@ hdl/irm_core.sv @@
// ----------------------------------------------------------------------------
// irm_core
// input register, raster counters, running addresses and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_rotate_mirror_address_gen_macros.svh"

module irm_core import irm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire geom_t               geom,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [PIXEL_W-1:0]  pixel_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [ADDR_W-1:0]        dest_offset,
    output logic [PIXEL_W-1:0]       pixel_out,
    output logic [STRIDE_W-1:0]      dest_row_stride,
    output logic                     frame_last
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [PIXEL_W-1:0]  pixel_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CNT_W-1:0]    col_reg;
    logic [CNT_W-1:0]    col_next;
    logic [CNT_W-1:0]    row_reg;
    logic [CNT_W-1:0]    row_next;
    logic [ADDR_W-1:0]   paddr_reg;
    logic [ADDR_W-1:0]   paddr_next;
    logic [ADDR_W-1:0]   raddr_reg;
    logic [ADDR_W-1:0]   raddr_next;
    logic [ADDR_W-1:0]   offset_reg;
    logic [PIXEL_W-1:0]  pixel_out_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic                last_reg;
    logic                advance;
    logic                first;
    logic                row_end;
    logic                frame_end;
    logic [DIM_W-1:0]    col_inc;
    logic [DIM_W-1:0]    row_inc;
    logic [ADDR_W-1:0]   cur_paddr;
    logic [ADDR_W-1:0]   cur_raddr;
    logic [ADDR_W-1:0]   row_step_addr;

    always_comb
    begin
        advance  = in_valid_reg && (!out_valid_reg || out_ready);
        in_ready = !in_valid_reg || advance;

        in_valid_next  = in_ready ? in_valid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

        // frame start loads both addresses
        first     = (col_reg == '0) && (row_reg == '0);
        cur_paddr = first ? geom.start : paddr_reg;
        cur_raddr = first ? geom.start : raddr_reg;

        col_inc   = DIM_W'(col_reg) + DIM_W'(1);
        row_inc   = DIM_W'(row_reg) + DIM_W'(1);
        row_end   = (col_inc >= geom.width);
        frame_end = row_end && (row_inc >= geom.height);

        row_step_addr = cur_raddr + geom.rstep;

        col_next   = col_reg;
        row_next   = row_reg;
        paddr_next = paddr_reg;
        raddr_next = raddr_reg;
        if (advance)
        begin
            if (row_end)
            begin
                col_next   = '0;
                row_next   = frame_end ? '0 : row_inc[CNT_W-1:0];
                raddr_next = row_step_addr;
                paddr_next = row_step_addr;
            end
            else
            begin
                col_next   = col_inc[CNT_W-1:0];
                paddr_next = cur_paddr + geom.pstep;
                raddr_next = cur_raddr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            paddr_reg     <= '0;
            raddr_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            paddr_reg     <= paddr_next;
            raddr_reg     <= raddr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pixel_reg <= pixel_data;
        if (advance)
        begin
            offset_reg    <= cur_paddr;
            pixel_out_reg <= pixel_reg;
            stride_reg    <= geom.stride;
            last_reg      <= frame_end;
        end
    end

    assign out_valid       = out_valid_reg;
    assign dest_offset     = offset_reg;
    assign pixel_out       = pixel_out_reg;
    assign dest_row_stride = stride_reg;
    assign frame_last      = last_reg;

    `IRM_ASSERT_NEXT(a_frame_wrap, advance && frame_end, (col_reg == '0) && (row_reg == '0), "counters not cleared after last pixel")
    `IRM_ASSERT_NEXT(a_row_restart, advance && row_end, paddr_reg == raddr_reg, "pixel address not reloaded at row end")
    `IRM_ASSERT_NEXT(a_col_step, advance && !row_end, col_reg == $past(col_reg) + 1'b1, "column counter skipped")
    `IRM_ASSERT_NEXT(a_item_held, in_valid_reg && !advance, in_valid_reg && $stable(pixel_reg), "stalled pixel lost")

endmodule

`default_nettype wire
